// ----- rtl/core/mrws_pkg.sv -----
// ----------------------------------------------------------------------------
// mrws_pkg
// Shared widths and constants of the topic arrival statistics block.
// ----------------------------------------------------------------------------
`default_nettype none
package mrws_pkg;
    localparam int NUM_TOPICS = 8;
    localparam int WINDOW_MAX = 64;
    localparam int TW = $clog2(NUM_TOPICS);
    localparam int HW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int AW = TW + HW;
    localparam int IVW = 40;
    localparam int NSW = 63;
    localparam logic [IVW-1:0] IV_MAX = {IVW{1'b1}};
    localparam logic [39:0] RATE_NUM = 40'd1000000000000;
    localparam logic [39:0] FLOOR_RST = 40'd2000000000;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_WINDOW = 2'd1;
    localparam logic [1:0] CFG_FLOOR  = 2'd2;
    localparam logic [1:0] CFG_SIGMA  = 2'd3;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_QUERY   = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/core/message_rate_window_statistics.sv -----
// Arrival: S_ARR then S_ARR2; a restart or a disabled slot returns to idle from S_ARR.
// Query over n stored intervals, in order: sum walk, mean divide, square walk on a
// shared 40x20 multiplier, variance divide, root, rate divide, then finish and output.
// Empty window or disabled slot: the query goes straight to the output. One item at a
// time; the next is taken once the result has been accepted. Sync active-low reset
// clears control state.
// ----------------------------------------------------------------------------
// message_rate_window_statistics
// Per-topic inter-arrival window: mean, deviation, min, max, rate, timeout.
// ----------------------------------------------------------------------------
`default_nettype none
module message_rate_window_statistics
    import mrws_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [39:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: topic_id[2:0], now_ns[65:3], zero pad to 72
    input  wire logic [71:0]  s_axis_tdata,
    // tuser: req_type
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: topic_known[0], topic_active[1], samples[8:2], mean_ns[48:9],
    // rate_millihz[88:49], stddev_ns[128:89], min_ns[168:129], max_ns[208:169],
    // timeout_ns[252:209], timed_out[253], window_limit[260:254], pad to 264
    output logic [263:0]      m_axis_tdata
);
    localparam logic [4:0] S_IDLE = 5'd0, S_ARR = 5'd1, S_ARR2 = 5'd2,
        S_RD1 = 5'd3, S_ACC1 = 5'd4, S_MEAN = 5'd5, S_RD2 = 5'd6, S_ACC2 = 5'd7,
        S_VDIV = 5'd8, S_SQRT = 5'd9, S_SQM = 5'd10, S_THR = 5'd11,
        S_RDIV = 5'd12, S_FIN = 5'd13, S_OUT = 5'd14, S_MDIV = 5'd15;

    logic [4:0] r_st;
    logic [7:0] r_en;
    logic [6:0] r_win;
    logic [39:0] r_floor;
    logic [3:0] r_sig;
    logic [NUM_TOPICS-1:0] r_act, r_started;
    logic [NSW-1:0] r_start [NUM_TOPICS];
    logic [NSW-1:0] r_last [NUM_TOPICS];
    logic [CW-1:0] r_fill [NUM_TOPICS];
    logic [HW-1:0] r_head [NUM_TOPICS];
    logic [IVW-1:0] r_mem [NUM_TOPICS*WINDOW_MAX];
    logic [IVW-1:0] r_rd;

    logic [TW-1:0] r_t;
    logic [NSW-1:0] r_now;
    logic [CW-1:0] r_n, r_k;
    logic [HW-1:0] r_addr;
    logic [46:0] r_sum;
    logic [IVW-1:0] r_mn, r_mx, r_mean, r_sd;
    logic [127:0] r_v;
    logic [127:0] r_q;
    logic [46:0] r_rem;
    logic [7:0] r_cnt;
    logic [47:0] r_root;
    logic [95:0] r_sq;
    logic [95:0] r_rsq;
    logic [43:0] r_thr;
    logic [39:0] r_rate;
    logic [39:0] r_rq;
    logic [40:0] r_rr;
    logic r_ph;
    logic [IVW-1:0] r_dq;

    logic [CW-1:0] w_eff;
    always_comb begin
        if (r_win == 7'd0) w_eff = CW'(1);
        else if (r_win > 7'(WINDOW_MAX)) w_eff = CW'(WINDOW_MAX);
        else w_eff = CW'(r_win);
    end

    logic [TW-1:0] w_tin;
    logic [NSW-1:0] w_nin;
    assign w_tin = s_axis_tdata[TW-1:0];
    assign w_nin = s_axis_tdata[NSW+2:3];
    assign s_axis_tready = (r_st == S_IDLE) && !m_axis_tvalid;

    logic w_on;
    assign w_on = r_en[r_t];

    logic [IVW-1:0] w_d;
    assign w_d = (r_rd >= r_mean) ? r_rd - r_mean : r_mean - r_rd;

    logic [IVW-1:0] w_ma;
    logic [19:0] w_mb;
    logic [59:0] w_mp;
    logic [127:0] w_pp;
    assign w_ma = r_ph ? r_dq : w_d;
    assign w_mb = r_ph ? r_dq[39:20] : w_d[19:0];
    assign w_mp = {20'd0, w_ma} * {40'd0, w_mb};
    assign w_pp = r_ph ? {48'd0, w_mp, 20'd0} : {68'd0, w_mp};

    logic [47:0] w_c;
    assign w_c = r_root | (48'd1 << r_cnt[5:0]);

    logic [95:0] w_sqc;
    assign w_sqc = r_rsq + ({48'd0, r_root} << (r_cnt[5:0] + 6'd1))
        + (96'd1 << {r_cnt[5:0], 1'b0});

    logic [NSW-1:0] w_iv;
    assign w_iv = (r_now >= r_last[r_t]) ? r_now - r_last[r_t] : '0;

    logic [47:0] w_rem2;
    assign w_rem2 = {r_rem, r_q[127]};
    logic [41:0] w_rr2;
    assign w_rr2 = {r_rr, r_rq[39]};

    logic w_tout;
    assign w_tout = (r_now >= r_last[r_t]) && ((r_now - r_last[r_t]) > NSW'(r_thr));

    logic [263:0] w_out;
    always_comb begin
        w_out = '0;
        w_out[260:254] = (r_en != '0) ? w_eff : '0;
        if (w_on) begin
            w_out[0] = 1'b1;
            w_out[1] = r_act[r_t];
            if (r_n != '0) begin
                w_out[8:2] = 7'(r_n);
                w_out[48:9] = r_mean;
                w_out[88:49] = w_tout ? '0 : r_rate;
                w_out[128:89] = r_sd;
                w_out[168:129] = r_mn;
                w_out[208:169] = r_mx;
                w_out[252:209] = r_thr;
                w_out[253] = w_tout;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_ARR2)
            r_mem[{r_t, r_head[r_t]}] <= (w_iv > NSW'(IV_MAX)) ? IV_MAX : w_iv[IVW-1:0];
        r_rd <= r_mem[{r_t, r_addr}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_en <= '0;
            r_win <= 7'd64;
            r_floor <= FLOOR_RST;
            r_sig <= 4'd5;
            r_act <= '0;
            r_started <= '0;
            for (int i = 0; i < NUM_TOPICS; i++) begin
                r_fill[i] <= '0;
                r_head[i] <= '0;
            end
            m_axis_tvalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENABLE: begin
                        r_en <= i_cfg_data[7:0];
                        r_act <= '0;
                        r_started <= '0;
                        for (int i = 0; i < NUM_TOPICS; i++) begin
                            r_fill[i] <= '0;
                            r_head[i] <= '0;
                        end
                    end
                    CFG_WINDOW: r_win <= i_cfg_data[6:0];
                    CFG_FLOOR:  r_floor <= i_cfg_data;
                    CFG_SIGMA:  r_sig <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_t <= w_tin;
                    r_now <= w_nin;
                    r_st <= (s_axis_tuser == REQ_QUERY) ? S_RD1 : S_ARR;
                    r_sum <= '0; r_mn <= IV_MAX; r_mx <= '0; r_v <= '0;
                    r_mean <= '0; r_sd <= '0; r_thr <= '0; r_rate <= '0;
                    r_n <= r_fill[w_tin]; r_k <= '0;
                    r_addr <= HW'(r_head[w_tin] - HW'(r_fill[w_tin]));
                end
                S_ARR: begin
                    if (!w_on) r_st <= S_IDLE;
                    else begin
                        r_act[r_t] <= 1'b1;
                        if (!r_started[r_t] || r_start[r_t] > r_now) begin
                            r_started[r_t] <= 1'b1;
                            r_start[r_t] <= r_now;
                            r_last[r_t] <= r_now;
                            r_fill[r_t] <= '0;
                            r_head[r_t] <= '0;
                            r_st <= S_IDLE;
                        end else r_st <= S_ARR2;
                    end
                end
                S_ARR2: begin
                    r_head[r_t] <= r_head[r_t] + HW'(1);
                    if (r_fill[r_t] < w_eff) r_fill[r_t] <= r_fill[r_t] + CW'(1);
                    else if (r_fill[r_t] == CW'(WINDOW_MAX) && r_fill[r_t] > w_eff)
                        r_fill[r_t] <= r_fill[r_t] - CW'(1);
                    r_last[r_t] <= r_now;
                    r_st <= S_IDLE;
                end
                S_RD1: begin
                    if (!w_on || r_n == '0) r_st <= S_OUT;
                    else begin
                        r_addr <= r_addr + HW'(1);
                        r_st <= S_ACC1;
                    end
                end
                S_ACC1: begin
                    r_sum <= r_sum + 47'(r_rd);
                    if (r_rd < r_mn) r_mn <= r_rd;
                    if (r_rd > r_mx) r_mx <= r_rd;
                    r_addr <= r_addr + HW'(1);
                    r_k <= r_k + CW'(1);
                    if (r_k + CW'(1) == r_n) r_st <= S_MEAN;
                end
                S_MEAN: begin
                    r_q <= {r_sum, 81'd0};
                    r_rem <= '0;
                    r_cnt <= 8'd47;
                    r_st <= S_MDIV;
                end
                S_MDIV: begin
                    if (w_rem2 >= 48'(r_n)) begin
                        r_rem <= 47'(w_rem2 - 48'(r_n));
                        r_q <= {r_q[126:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2[46:0];
                        r_q <= {r_q[126:0], 1'b0};
                    end
                    if (r_cnt == 8'd1) begin
                        r_addr <= HW'(r_head[r_t] - HW'(r_n));
                        r_k <= '0;
                        r_st <= S_RD2;
                    end
                    r_cnt <= r_cnt - 8'd1;
                end
                S_RD2: begin
                    r_mean <= r_q[39:0];
                    r_addr <= r_addr + HW'(1);
                    r_ph <= 1'b0;
                    r_st <= S_ACC2;
                end
                S_ACC2: begin
                    r_v <= r_v + w_pp;
                    r_ph <= !r_ph;
                    if (!r_ph) r_dq <= w_d;
                    else begin
                        r_addr <= r_addr + HW'(1);
                        r_k <= r_k + CW'(1);
                        if (r_k + CW'(1) == r_n) begin
                            r_st <= S_VDIV;
                            r_cnt <= 8'd128;
                            r_rem <= '0;
                        end
                    end
                end
                S_VDIV: begin
                    if (r_cnt == 8'd128) r_q <= r_v;
                    else begin
                        if (w_rem2 >= 48'(r_n)) begin
                            r_rem <= 47'(w_rem2 - 48'(r_n));
                            r_q <= {r_q[126:0], 1'b1};
                        end else begin
                            r_rem <= w_rem2[46:0];
                            r_q <= {r_q[126:0], 1'b0};
                        end
                    end
                    if (r_cnt == 8'd0) begin
                        r_root <= '0;
                        r_rsq <= '0;
                        r_cnt <= 8'd47;
                        r_st <= S_SQM;
                    end else r_cnt <= r_cnt - 8'd1;
                end
                S_SQM: begin
                    r_sq <= w_sqc;
                    r_st <= S_SQRT;
                end
                S_SQRT: begin
                    if ({32'd0, r_sq} <= r_q) begin
                        r_root <= w_c;
                        r_rsq <= r_sq;
                    end
                    if (r_cnt == 8'd0) r_st <= S_THR;
                    else begin
                        r_cnt <= r_cnt - 8'd1;
                        r_st <= S_SQM;
                    end
                end
                S_THR: begin
                    r_sd <= (r_root > 48'(IV_MAX)) ? IV_MAX : r_root[39:0];
                    r_rq <= RATE_NUM;
                    r_rr <= '0;
                    r_cnt <= 8'd40;
                    r_st <= S_RDIV;
                end
                S_RDIV: begin
                    if (r_cnt == 8'd40) begin
                        r_thr <= 44'(r_mean) + 44'(r_sd) * 44'(r_sig);
                        r_cnt <= r_cnt - 8'd1;
                    end else begin
                        if (r_mean != '0 && w_rr2 >= 42'(r_mean)) begin
                            r_rr <= 41'(w_rr2 - 42'(r_mean));
                            r_rq <= {r_rq[38:0], 1'b1};
                        end else begin
                            r_rr <= w_rr2[40:0];
                            r_rq <= {r_rq[38:0], 1'b0};
                        end
                        if (r_cnt == 8'd0) r_st <= S_FIN;
                        else r_cnt <= r_cnt - 8'd1;
                    end
                end
                S_FIN: begin
                    r_rate <= (r_mean == '0) ? '0 : r_rq;
                    if (r_thr < 44'(r_floor)) r_thr <= 44'(r_floor);
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tdata <= w_out;
                    if (w_on && r_n != '0 && w_tout) begin
                        r_fill[r_t] <= '0;
                        r_head[r_t] <= '0;
                        r_started[r_t] <= 1'b0;
                    end
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |=> m_axis_tvalid)
        else $error("result not shown");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_ARR2) |=> (r_st == S_IDLE) && !m_axis_tvalid)
        else $error("arrival produced result");
endmodule
`default_nettype wire
